[src/i2c_master_bit_sequencer_top_macros.svh]
// Assertion macros used by the sequencer top level.
`ifndef I2C_MASTER_BIT_SEQUENCER_TOP_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define I2CMBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define I2CMBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CMBS_ASSERT(lbl, clk, rst_n, prop, msg)
`define I2CMBS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[src/i2cmbs_pkg.sv]
// Types, codes and constants of the I2C master bit sequencer.
package i2cmbs_pkg;

    localparam int unsigned PHASE_W     = 10;
    localparam int unsigned IDX_W       = 5;
    localparam logic [PHASE_W-1:0] PHASE_RESET = 10'd10;
    localparam logic [PHASE_W-1:0] PHASE_MIN   = 10'd1;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_SACK  = 3'd5,
        OP_RACK  = 3'd6
    } t_op;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_byte;
        logic       ack_out;
        logic       sda_in;
    } t_cmd_beat;

    typedef struct packed {
        logic              scl;
        logic              sda;
        t_op               cmd;
        logic [IDX_W-1:0]  idx;
        logic [PHASE_W-1:0] pc;
        logic [7:0]        shreg;
        logic              ack_seen;
        logic              running;
        logic [7:0]        tx;
    } t_state;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_in;
        logic       rejected;
    } t_res;

    // Number of primitives each command expands into.
    function automatic logic [IDX_W-1:0] prim_count(input t_op cmd);
        case (cmd)
            OP_START: prim_count = 5'd4;
            OP_STOP:  prim_count = 5'd3;
            OP_WRITE: prim_count = 5'd24;
            OP_READ:  prim_count = 5'd25;
            OP_SACK:  prim_count = 5'd3;
            OP_RACK:  prim_count = 5'd4;
            default:  prim_count = 5'd0;
        endcase
    endfunction

endpackage

[src/i2cmbs_in_if.sv]
// Command and tick channel of the sequencer.
interface i2cmbs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       ack_out;
    logic       sda_in;

    modport source (output valid, output opcode, output data_byte, output ack_out,
                    output sda_in, input ready);
    modport sink   (input valid, input opcode, input data_byte, input ack_out,
                    input sda_in, output ready);
endinterface

[src/i2cmbs_out_if.sv]
// Result channel of the sequencer.
interface i2cmbs_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_in;
    logic       rejected;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output read_byte, output ack_in, output rejected,
                    input ready);
    modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                    input done_res, input read_byte, input ack_in, input rejected,
                    output ready);
endinterface

[src/i2cmbs_core.sv]
// Next-state and result logic for one command or tick beat.
module i2cmbs_core (
    input  i2cmbs_pkg::t_state              i_state,
    input  i2cmbs_pkg::t_cmd_beat           i_beat,
    input  logic [i2cmbs_pkg::PHASE_W-1:0]  i_phase_ticks,
    output i2cmbs_pkg::t_state              o_state,
    output i2cmbs_pkg::t_res                o_res
);
    import i2cmbs_pkg::*;

    typedef struct packed {
        logic [2:0] bit_no;
        logic [1:0] slot;
    } t_split;

    // Split an index into bit number and slot within a three-primitive group.
    function automatic t_split split3(input logic [IDX_W-1:0] idx);
        logic [8:0] prod;
        logic [3:0] q;
        logic [5:0] q3;
        logic [5:0] r;
        t_split     s;
        prod     = {4'b0, idx} * 9'd11;
        q        = prod[8:5];
        q3       = {2'b0, q} + {1'b0, q, 1'b0};
        r        = {1'b0, idx} - q3;
        s.bit_no = q[2:0];
        s.slot   = r[1:0];
        return s;
    endfunction

    t_state            n;
    logic              done;
    logic              rej;
    logic              prim_en;
    logic [IDX_W-1:0]  prim_idx;
    logic [IDX_W-1:0]  idx_inc;
    logic [PHASE_W-1:0] pc_dec;
    logic              is_cmd;
    t_split            sp;

    always_comb begin
        n        = i_state;
        done     = 1'b0;
        rej      = 1'b0;
        prim_en  = 1'b0;
        prim_idx = '0;
        idx_inc  = i_state.idx + 5'd1;
        pc_dec   = (i_state.pc != '0) ? i_state.pc - 10'd1 : i_state.pc;
        is_cmd   = i_beat.opcode inside {[OP_START:OP_RACK]};
        sp       = '0;

        if (is_cmd) begin
            if (i_state.running) begin
                rej = 1'b1;
            end else begin
                n.cmd     = t_op'(i_beat.opcode);
                n.idx     = '0;
                n.tx      = (i_beat.opcode == OP_SACK) ? {7'b0, i_beat.ack_out}
                                                       : i_beat.data_byte;
                if (i_beat.opcode == OP_READ) begin
                    n.shreg = '0;
                end
                n.running = 1'b1;
                n.pc      = i_phase_ticks;
                prim_en   = 1'b1;
            end
        end else if (i_state.running) begin
            n.pc = pc_dec;
            if (pc_dec == '0) begin
                if (idx_inc >= prim_count(i_state.cmd)) begin
                    n.running = 1'b0;
                    n.cmd     = OP_TICK;
                    n.idx     = '0;
                    done      = 1'b1;
                end else begin
                    n.idx    = idx_inc;
                    n.pc     = i_phase_ticks;
                    prim_en  = 1'b1;
                    prim_idx = idx_inc;
                end
            end
        end

        // Apply the primitive that opens the new phase.
        if (prim_en) begin
            case (n.cmd)
                OP_START: begin
                    case (prim_idx)
                        5'd0:    n.sda = 1'b1;
                        5'd1:    n.scl = 1'b1;
                        5'd2:    n.sda = 1'b0;
                        default: n.scl = 1'b0;
                    endcase
                end
                OP_STOP: begin
                    case (prim_idx)
                        5'd0:    n.sda = 1'b0;
                        5'd1:    n.scl = 1'b1;
                        default: n.sda = 1'b1;
                    endcase
                end
                OP_WRITE: begin
                    sp = split3(prim_idx);
                    case (sp.slot)
                        2'd0:    n.sda = n.tx[3'd7 - sp.bit_no];
                        2'd1:    n.scl = 1'b1;
                        default: n.scl = 1'b0;
                    endcase
                end
                OP_READ: begin
                    if (prim_idx == '0) begin
                        n.sda = 1'b1;
                    end else begin
                        sp = split3(prim_idx - 5'd1);
                        case (sp.slot)
                            2'd0: n.scl = 1'b1;
                            2'd1: begin
                                if (i_beat.sda_in) begin
                                    n.shreg[3'd7 - sp.bit_no] = 1'b1;
                                end
                            end
                            default: n.scl = 1'b0;
                        endcase
                    end
                end
                OP_SACK: begin
                    case (prim_idx)
                        5'd0:    n.sda = n.tx[0];
                        5'd1:    n.scl = 1'b1;
                        default: n.scl = 1'b0;
                    endcase
                end
                OP_RACK: begin
                    case (prim_idx)
                        5'd0:    n.sda = 1'b1;
                        5'd1:    n.scl = 1'b1;
                        5'd2:    n.ack_seen = i_beat.sda_in;
                        default: n.scl = 1'b0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_state         = n;
    assign o_res.scl_out   = n.scl;
    assign o_res.sda_out   = n.sda;
    assign o_res.busy_res  = n.running;
    assign o_res.done_res  = done;
    assign o_res.read_byte = n.shreg;
    assign o_res.ack_in    = n.ack_seen;
    assign o_res.rejected  = rej;

endmodule

[src/i2cmbs_out_reg.sv]
// Result register that holds a beat until the receiver takes it.
module i2cmbs_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  i2cmbs_pkg::t_res i_res,
    output logic             o_can_push,
    i2cmbs_out_if.source     o_out
);
    import i2cmbs_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_can_push = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_push) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_push && i_push) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.scl_out   = r_res.scl_out;
    assign o_out.sda_out   = r_res.sda_out;
    assign o_out.busy_res  = r_res.busy_res;
    assign o_out.done_res  = r_res.done_res;
    assign o_out.read_byte = r_res.read_byte;
    assign o_out.ack_in    = r_res.ack_in;
    assign o_out.rejected  = r_res.rejected;

endmodule

[src/i2c_master_bit_sequencer_top.sv]
// Top level of the I2C master bit sequencer.
//
// Usage: each beat on i_in is a tick or a command (start, stop, write byte,
// read byte, send ack, receive ack). Every tick carries the sampled SDA
// level in sda_in. Each beat yields exactly one result beat on o_out with
// the driven SCL/SDA levels, busy and done flags, the byte assembled by the
// latest read, the latest sampled ack and a rejected flag for commands that
// arrive while a sequence is still running.
// The phase length register is written through i_cfg_we/i_cfg_wdata; the user writes it
// only while idle, which the block does not enforce; a written zero is stored as one.
// Each result beat is registered and shows in the cycle after its beat is taken.
// Throughput: one beat per cycle unless stalled; the state update is a single
// combinational pass from the state registers into the result register.
// Stall: while the result register holds an untaken beat and the receiver
// keeps ready low, i_in.ready drops; the beat is taken in the same cycle the
// receiver takes the waiting result.
// Reset: synchronous, active low; both lines released high, sequencer idle,
// phase length back to ten ticks, no result pending.
module i2c_master_bit_sequencer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [i2cmbs_pkg::PHASE_W-1:0] i_cfg_wdata,
    i2cmbs_in_if.sink                      i_in,
    i2cmbs_out_if.source                   o_out
);
    import i2cmbs_pkg::*;

    `include "i2c_master_bit_sequencer_top_macros.svh"

    logic [PHASE_W-1:0] r_phase;
    t_state             r_state;
    t_state             n_state;
    t_res               core_res;
    t_cmd_beat          beat;
    logic               can_push;
    logic               accept;

    // Gather the input beat into one bundle for the core.
    assign beat.opcode    = i_in.opcode;
    assign beat.data_byte = i_in.data_byte;
    assign beat.ack_out   = i_in.ack_out;
    assign beat.sda_in    = i_in.sda_in;

    assign i_in.ready = can_push;
    assign accept     = i_in.valid && can_push;

    // Phase length register; a zero write is held as the minimum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PHASE_RESET;
        end else if (i_cfg_we) begin
            r_phase <= (i_cfg_wdata == '0) ? PHASE_MIN : i_cfg_wdata;
        end
    end

    i2cmbs_core u_core (
        .i_state       (r_state),
        .i_beat        (beat),
        .i_phase_ticks (r_phase),
        .o_state       (n_state),
        .o_res         (core_res)
    );

    // Advance the sequencer state only on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.scl      <= 1'b1;
            r_state.sda      <= 1'b1;
            r_state.cmd      <= OP_TICK;
            r_state.idx      <= '0;
            r_state.pc       <= '0;
            r_state.shreg    <= '0;
            r_state.ack_seen <= 1'b0;
            r_state.running  <= 1'b0;
            r_state.tx       <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    i2cmbs_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_in.valid),
        .i_res      (core_res),
        .o_can_push (can_push),
        .o_out      (o_out)
    );

    // A running sequence always has a live phase count.
    `I2CMBS_ASSERT(a_pc_live, i_clk, i_rst_n, r_state.running |-> (r_state.pc != '0), "phase count zero while running")
    // Idle leaves the primitive index parked at zero.
    `I2CMBS_ASSERT(a_idle_idx, i_clk, i_rst_n, !r_state.running |-> (r_state.idx == '0), "index not cleared when idle")
    // A rejected command leaves the sequence running.
    `I2CMBS_ASSERT(a_rej_busy, i_clk, i_rst_n, (accept && core_res.rejected) |=> r_state.running, "rejected command stopped the sequence")
    // Done and busy never show together.
    `I2CMBS_ASSERT(a_done_idle, i_clk, i_rst_n, (accept && core_res.done_res) |-> !core_res.busy_res, "done while still busy")
    // The phase length never holds zero.
    `I2CMBS_ASSERT(a_phase_nz, i_clk, i_rst_n, r_phase != '0, "phase length zero")

endmodule
